@@ rtl/modbus_write_frame_builder_macros.svh @@
// Assertion macros used by the frame builder top level.
`ifndef MODBUS_WRITE_FRAME_BUILDER_MACROS_SVH
`define MODBUS_WRITE_FRAME_BUILDER_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define MWFB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define MWFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mwfb_pkg.sv @@
// Types, constants and the CRC step function of the Modbus write frame builder.
package mwfb_pkg;

    // Function codes and fixed fields of a write-multiple frame
    localparam logic [7:0] FC_WRITE_SINGLE  = 8'h06;
    localparam logic [7:0] FC_WRITE_MULTI   = 8'h10;
    localparam logic [7:0] MULTI_QTY_HI     = 8'h00;
    localparam logic [7:0] MULTI_QTY_LO     = 8'h02;
    localparam logic [7:0] MULTI_BYTE_COUNT = 8'h04;

    // Frame lengths in bytes, CRC included
    localparam int LEN_SINGLE = 8;
    localparam int LEN_MULTI  = 13;
    localparam int IDX_W      = 4;

    localparam logic [IDX_W-1:0] LAST_SINGLE   = IDX_W'(LEN_SINGLE - 1);
    localparam logic [IDX_W-1:0] LAST_MULTI    = IDX_W'(LEN_MULTI - 1);
    localparam logic [IDX_W-1:0] CRC_LO_SINGLE = IDX_W'(LEN_SINGLE - 2);
    localparam logic [IDX_W-1:0] CRC_LO_MULTI  = IDX_W'(LEN_MULTI - 2);

    // Byte positions of the frame body
    localparam logic [IDX_W-1:0] B_DEV    = 4'd0;
    localparam logic [IDX_W-1:0] B_FC     = 4'd1;
    localparam logic [IDX_W-1:0] B_RA_HI  = 4'd2;
    localparam logic [IDX_W-1:0] B_RA_LO  = 4'd3;
    localparam logic [IDX_W-1:0] B_S_VAHI = 4'd4;
    localparam logic [IDX_W-1:0] B_S_VALO = 4'd5;
    localparam logic [IDX_W-1:0] B_M_QHI  = 4'd4;
    localparam logic [IDX_W-1:0] B_M_QLO  = 4'd5;
    localparam logic [IDX_W-1:0] B_M_BC   = 4'd6;
    localparam logic [IDX_W-1:0] B_M_VAHI = 4'd7;
    localparam logic [IDX_W-1:0] B_M_VALO = 4'd8;
    localparam logic [IDX_W-1:0] B_M_VBHI = 4'd9;
    localparam logic [IDX_W-1:0] B_M_VBLO = 4'd10;

    // Configuration register map
    localparam int PADDR_W = 4;
    localparam logic [1:0] CFG_DEV_ADDR = 2'd0;
    localparam logic [1:0] CFG_POLY     = 2'd1;
    localparam logic [1:0] CFG_INIT     = 2'd2;

    localparam logic [7:0]  RST_DEV_ADDR = 8'h01;
    localparam logic [15:0] RST_POLY     = 16'hA001;
    localparam logic [15:0] RST_INIT     = 16'hFFFF;

    typedef struct packed {
        logic        func;
        logic [15:0] reg_addr;
        logic [15:0] value_a;
        logic [15:0] value_b;
    } t_in_item;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  dev_addr;
        logic [15:0] poly;
        logic [15:0] init;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic             capture;
        logic             load;
        logic             first;
        logic             last;
        logic [IDX_W-1:0] idx;
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic multi;
    } t_ctrl_stat;

    // Fold one byte into a reflected CRC-16, one bit per step
    function automatic logic [15:0] crc_add(input logic [15:0] crc_in,
                                            input logic [7:0]  data,
                                            input logic [15:0] poly);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ poly;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/mwfb_ctrl.sv @@
// Frame sequencer: accepts a command and steps the byte index through the frame.
module mwfb_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_out_stall,
    input  mwfb_pkg::t_ctrl_stat  i_stat,
    output mwfb_pkg::t_ctrl_cmd   o_cmd,
    output logic                  o_in_stall,
    output logic                  o_out_valid
);
    import mwfb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SEND = 2'b10
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_out_valid, n_out_valid;
    logic [IDX_W-1:0] w_last_idx;
    logic             w_slot_free;
    logic             w_accept;

    assign w_last_idx  = i_stat.multi ? LAST_MULTI : LAST_SINGLE;
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    // Issue commands to the datapath
    always_comb begin
        o_cmd.capture = w_accept;
        o_cmd.load    = (r_state == ST_SEND) && w_slot_free;
        o_cmd.idx     = r_idx;
        o_cmd.first   = (r_idx == B_DEV);
        o_cmd.last    = (r_idx == w_last_idx);
    end

    // Advance through the frame one byte per free output slot
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_SEND;
                    n_idx   = B_DEV;
                end
            end
            ST_SEND: begin
                if (o_cmd.load) begin
                    if (o_cmd.last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold the output valid until the transaction completes
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ rtl/mwfb_dp.sv @@
// Frame datapath: command capture, byte selection, running CRC and output register.
module mwfb_dp (
    input  logic                  i_clk,
    input  mwfb_pkg::t_in_item    i_in_data,
    input  mwfb_pkg::t_cfg        i_cfg,
    input  mwfb_pkg::t_ctrl_cmd   i_cmd,
    output mwfb_pkg::t_ctrl_stat  o_stat,
    output mwfb_pkg::t_out_item   o_out_data
);
    import mwfb_pkg::*;

    t_in_item         r_item;
    logic [15:0]      r_crc;
    t_out_item        r_out;
    logic [IDX_W-1:0] w_crc_lo_idx;
    logic             w_multi;
    logic             w_is_crc;
    logic [7:0]       w_body_byte;
    logic [7:0]       w_byte;
    logic [15:0]      w_crc_base;

    assign w_multi      = r_item.func;
    assign o_stat.multi = w_multi;
    assign w_crc_lo_idx = w_multi ? CRC_LO_MULTI : CRC_LO_SINGLE;
    assign w_is_crc     = (i_cmd.idx >= w_crc_lo_idx);
    assign w_crc_base   = i_cmd.first ? i_cfg.init : r_crc;

    // Select the frame body byte at the current index
    always_comb begin
        w_body_byte = 8'h00;
        case (i_cmd.idx)
            B_DEV:   w_body_byte = i_cfg.dev_addr;
            B_FC:    w_body_byte = w_multi ? FC_WRITE_MULTI : FC_WRITE_SINGLE;
            B_RA_HI: w_body_byte = r_item.reg_addr[15:8];
            B_RA_LO: w_body_byte = r_item.reg_addr[7:0];
            default: begin
                if (w_multi) begin
                    case (i_cmd.idx)
                        B_M_QHI:  w_body_byte = MULTI_QTY_HI;
                        B_M_QLO:  w_body_byte = MULTI_QTY_LO;
                        B_M_BC:   w_body_byte = MULTI_BYTE_COUNT;
                        B_M_VAHI: w_body_byte = r_item.value_a[15:8];
                        B_M_VALO: w_body_byte = r_item.value_a[7:0];
                        B_M_VBHI: w_body_byte = r_item.value_b[15:8];
                        B_M_VBLO: w_body_byte = r_item.value_b[7:0];
                        default:  w_body_byte = 8'h00;
                    endcase
                end else begin
                    case (i_cmd.idx)
                        B_S_VAHI: w_body_byte = r_item.value_a[15:8];
                        B_S_VALO: w_body_byte = r_item.value_a[7:0];
                        default:  w_body_byte = 8'h00;
                    endcase
                end
            end
        endcase
    end

    // Append the CRC low byte first
    always_comb begin
        if (!w_is_crc) begin
            w_byte = w_body_byte;
        end else if (i_cmd.idx == w_crc_lo_idx) begin
            w_byte = r_crc[7:0];
        end else begin
            w_byte = r_crc[15:8];
        end
    end

    // Capture the command, fold body bytes into the CRC, load the output slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_data;
        end
        if (i_cmd.load && !w_is_crc) begin
            r_crc <= crc_add(w_crc_base, w_byte, i_cfg.poly);
        end
        if (i_cmd.load) begin
            r_out.tx_byte   <= w_byte;
            r_out.last_byte <= i_cmd.last;
        end
    end

    assign o_out_data = r_out;

endmodule

@@ rtl/modbus_write_frame_builder.sv @@
// Modbus RTU write-request frame builder: takes one write command per transaction
// and emits the request frame one byte per output transaction. A single-register
// write gives 8 bytes, a two-register write 13 bytes, the CRC-16 last, low byte
// first. The byte sequencer emits one byte per cycle while the output is not stalled
// and folds each body byte, but not the CRC bytes, into the CRC in that cycle.
// A new command is accepted once the final CRC byte sits in the output register.
// Device address, polynomial and CRC start value are set through the APB port
// (byte addresses 0, 4, 8) and must only be changed while no frame is in flight.
module modbus_write_frame_builder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // command channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  mwfb_pkg::t_in_item          i_in_data,
    // frame byte channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output mwfb_pkg::t_out_item         o_out_data,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mwfb_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import mwfb_pkg::*;

    `include "modbus_write_frame_builder_macros.svh"

    t_cfg        r_cfg;
    t_ctrl_cmd   w_cmd;
    t_ctrl_stat  w_stat;
    logic [1:0]  w_reg_idx;
    logic        w_wr;
    logic        w_in_acc;
    logic        w_last_load;
    logic        w_last_out;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_wr      = psel && penable && pwrite && pready;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dev_addr <= RST_DEV_ADDR;
            r_cfg.poly     <= RST_POLY;
            r_cfg.init     <= RST_INIT;
        end else if (w_wr) begin
            unique case (w_reg_idx)
                CFG_DEV_ADDR: r_cfg.dev_addr <= pwdata[7:0];
                CFG_POLY:     r_cfg.poly     <= pwdata[15:0];
                CFG_INIT:     r_cfg.init     <= pwdata[15:0];
                default:      ;
            endcase
        end
    end

    // Read back configuration registers
    always_comb begin
        unique case (w_reg_idx)
            CFG_DEV_ADDR: prdata = {24'h000000, r_cfg.dev_addr};
            CFG_POLY:     prdata = {16'h0000, r_cfg.poly};
            CFG_INIT:     prdata = {16'h0000, r_cfg.init};
            default:      prdata = 32'h0000_0000;
        endcase
    end

    mwfb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    mwfb_dp u_dp (
        .i_clk      (i_clk),
        .i_in_data  (i_in_data),
        .i_cfg      (r_cfg),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_out_data (o_out_data)
    );

    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_last_load = w_cmd.load && w_cmd.last;
    assign w_last_out  = o_out_valid && o_out_data.last_byte;

    // A frame in flight blocks new commands
    `MWFB_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_in_acc, o_in_stall, "busy missing")
    // Staging the final CRC byte frees the sequencer
    `MWFB_ASSERT_NEXT(a_free_on_last, i_clk, i_rst_n, w_last_load, !o_in_stall, "still busy")
    // The sequencer frees up only by staging the final byte
    `MWFB_ASSERT_NOW(a_free_by_last, i_clk, i_rst_n, $fell(o_in_stall), w_last_out, "early free")

endmodule
